>>> hdl/iaf_pkg.sv
// Shared types, constants and helpers for the integer to ASCII formatter.
// No dependencies; imported by every module of the block.
`default_nettype none

package iaf_pkg;

    localparam int DIGIT_STORE_DEPTH = 16;
    localparam int IDX_W = $clog2(DIGIT_STORE_DEPTH);
    localparam int DIG_W = $clog2(DIGIT_STORE_DEPTH + 1);

    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        REQ_SDEC = 2'd0,
        REQ_UDEC = 2'd1,
        REQ_HEXL = 2'd2,
        REQ_HEXU = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [3:0]       wr_data;
        logic [IDX_W-1:0] rd_addr;
    } dst_ctrl_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {4'b0, d};
        end
        else if (upper)
        begin
            c = CHAR_UPPER + {4'b0, d - 4'd10};
        end
        else
        begin
            c = CHAR_LOWER + {4'b0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/iaf_step.sv
// Shared digit step: divide by ten (reciprocal multiply) or by sixteen (shift).
// Depends on iaf_pkg.
`default_nettype none

module iaf_step
    import iaf_pkg::*;
(
    input  wire logic [63:0] operand,
    input  wire logic        is_hex,
    output logic      [63:0] quotient,
    output logic      [3:0]  digit
);

    logic [63:0] prod;
    logic [28:0] q10;
    logic [3:0]  q10_x10;

    assign prod    = 64'(operand[31:0]) * 64'(RECIP_10);
    assign q10     = prod[63:RECIP_SHIFT];
    assign q10_x10 = {q10[0], 3'b000} + {q10[2:0], 1'b0};

    always_comb
    begin
        if (is_hex)
        begin
            quotient = {4'b0, operand[63:4]};
            digit    = operand[3:0];
        end
        else
        begin
            quotient = {35'b0, q10};
            digit    = operand[3:0] - q10_x10;
        end
    end

endmodule

`default_nettype wire

>>> hdl/iaf_digits.sv
// Digit store: one write and one read port over a small register file.
// Depends on iaf_pkg.
`default_nettype none

module iaf_digits
    import iaf_pkg::*;
(
    input  wire logic      clk,
    input  wire dst_ctrl_t ctrl,
    output logic [3:0]     rd_data
);

    logic [3:0] store_reg [DIGIT_STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            store_reg[ctrl.wr_addr] <= ctrl.wr_data;
        end
    end

    assign rd_data = store_reg[ctrl.rd_addr];

endmodule

`default_nettype wire

>>> hdl/integer_to_ascii_formatter.sv
// Top level: sequencer, shared digit step and output word register.
// Depends on iaf_pkg, iaf_step and iaf_digits.
//
// Prints one number as ASCII text, most significant character first, one word
// per character with last and a running count. An item is loaded, then converted
// one digit per cycle through the shared divide-by-ten / nibble step (up to ten
// decimal, up to sixteen hex), then printed one character word per cycle while
// the output side takes words. in_ready is high only between items; the last word
// may still wait at the output while the next item is loaded and converted.
`default_nettype none

module integer_to_ascii_formatter
    import iaf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] value,
    input  wire logic [1:0]  req_type,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [7:0]  character,
    output logic             last,
    output logic      [4:0]  char_count
);

    state_t            state_reg, state_next;
    logic [63:0]       rem_reg, rem_next;
    logic [DIG_W-1:0]  held_reg, held_next;
    logic              hex_reg, hex_next;
    logic              upper_reg, upper_next;
    logic              neg_reg, neg_next;
    logic [4:0]        count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    logic [4:0]        cnt_out_reg, cnt_out_next;

    logic              in_fire;
    logic              emit_fire;
    logic              emit_last;
    logic              conv_done;
    logic [63:0]       step_q;
    logic [3:0]        step_d;
    logic [3:0]        rd_data;
    logic [DIG_W-1:0]  held_inc;
    logic [DIG_W-1:0]  held_dec;
    logic [31:0]       low_word;
    logic              load_neg;
    dst_ctrl_t         dst_ctrl;

    iaf_step u_step (
        .operand  (rem_reg),
        .is_hex   (hex_reg),
        .quotient (step_q),
        .digit    (step_d)
    );

    iaf_digits u_digits (
        .clk     (clk),
        .ctrl    (dst_ctrl),
        .rd_data (rd_data)
    );

    assign in_fire   = in_valid && in_ready;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign emit_last = !neg_reg && (held_reg == DIG_W'(1));
    assign held_inc  = held_reg + 1'b1;
    assign held_dec  = held_reg - 1'b1;
    assign conv_done = (step_q == 64'd0) || (held_inc == DIG_W'(DIGIT_STORE_DEPTH));
    assign low_word  = value[31:0];
    assign load_neg  = (req_t'(req_type) == REQ_SDEC) && low_word[31];

    assign dst_ctrl.wr_en   = (state_reg == ST_CONVERT);
    assign dst_ctrl.wr_addr = held_reg[IDX_W-1:0];
    assign dst_ctrl.wr_data = step_d;
    assign dst_ctrl.rd_addr = held_dec[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (conv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        rem_next       = rem_reg;
        held_next      = held_reg;
        hex_next       = hex_reg;
        upper_next     = upper_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        cnt_out_next   = cnt_out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    hex_next   = req_type[1];
                    upper_next = (req_t'(req_type) == REQ_HEXU);
                    neg_next   = load_neg;
                    held_next  = '0;
                    count_next = '0;
                    if (req_type[1])
                    begin
                        rem_next = value;
                    end
                    else if (load_neg)
                    begin
                        rem_next = {32'b0, ~low_word + 32'd1};
                    end
                    else
                    begin
                        rem_next = {32'b0, low_word};
                    end
                end
            end
            ST_CONVERT:
            begin
                rem_next  = step_q;
                held_next = held_inc;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    count_next     = count_reg + 5'd1;
                    cnt_out_next   = count_reg + 5'd1;
                    last_next      = emit_last;
                    if (neg_reg)
                    begin
                        char_next = CHAR_MINUS;
                        neg_next  = 1'b0;
                    end
                    else
                    begin
                        char_next = digit_char(rd_data, upper_reg);
                        held_next = held_dec;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hex_reg     <= hex_next;
        upper_reg   <= upper_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;
    assign char_count = cnt_out_reg;

`ifndef NO_ASSERTIONS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= DIG_W'(DIGIT_STORE_DEPTH))
        else $error("digit count beyond store depth");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (held_reg != '0))
        else $error("emitting with no digits held");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_last) |=> (state_reg == ST_IDLE && out_valid_reg && last_reg))
        else $error("final word did not end the item");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (count_reg < 5'd17))
        else $error("character count out of range");
`endif

endmodule

`default_nettype wire
